### sv/sto_pkg.sv
// ----------------------------------------------------------------------------
// sto_pkg
// shared widths, constants, codes and helpers of the stereo tube overdrive
// ----------------------------------------------------------------------------
package sto_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TANH_SIZE_DEF   = 256;

  localparam int KNOB_W     = 16;
  localparam int KN_W       = 17;
  localparam int RATE_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // digit-serial multiplier: signed a times unsigned b, one digit of b a cycle
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 28;
  localparam int MUL_DIG_W = 4;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  // bit-serial divider for the cutoff ratio
  localparam int DIV_N_W = 37;
  localparam int DIV_D_W = 18;

  localparam int TANH_W  = 24;
  localparam int RATIO_W = 24;
  localparam int COEF_W  = 26;

  localparam logic [MUL_B_W-1:0] BIAS_K     = 28'd5033165;
  localparam logic [MUL_B_W-1:0] GAIN_POS_K = 28'd91750;
  localparam logic [MUL_B_W-1:0] GAIN_NEG_K = 28'd55706;
  localparam logic [MUL_B_W-1:0] FREQ_SPAN  = 28'd7000;
  localparam logic [28:0]        FREQ_BASE  = 29'd32768000;
  localparam logic [RATIO_W-1:0] RATIO_MAX  = 24'd8220836;
  localparam logic [MUL_A_W-1:0] TWO_PI_K   = 32'd105414357;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE   = 3'd0,
    CFG_TONE    = 3'd1,
    CFG_LEVEL   = 3'd2,
    CFG_WARMTH  = 3'd3,
    CFG_WET_MIX = 3'd4,
    CFG_RATE    = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BIAS,
    S_FREQ,
    S_DIV,
    S_COEF,
    S_DRY,
    S_POS,
    S_IDX,
    S_T0,
    S_T1,
    S_T2,
    S_INTERP,
    S_NEG,
    S_Y,
    S_FILT,
    S_FSAT,
    S_WET,
    S_MIXD,
    S_MIXW,
    S_RND,
    S_SAT,
    S_DONE
  } sto_state_e;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic        [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  // knob k read as k + (k >> 15), so full scale is exactly one
  function automatic logic [KN_W-1:0] knob(input logic [KNOB_W-1:0] k);
    return {1'b0, k} + KN_W'(k[KNOB_W-1]);
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [MUL_P_W-1:0] round_sh(
    input logic signed [MUL_P_W-1:0] v,
    input int unsigned               sh
  );
    logic signed [MUL_P_W-1:0] half;
    half = $signed(MUL_P_W'(1) << (sh - 1));
    return (v + half) >>> sh;
  endfunction

endpackage

### sv/stereo_tube_overdrive.sv
// ----------------------------------------------------------------------------
// stereo_tube_overdrive
// stereo asymmetric tanh overdrive with one-pole tone lowpass and dry/wet mix
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | left_in_i, right_in_i
//  out     | out       | out_valid_o/out_ready_i | left_out_o, right_out_o
//
//  a stereo pair is finished before the next one is taken in:
//  both channels go one after the other through a single digit-serial
//  multiplier (8 products a channel) plus rounding and table steps a
//  channel, then the pair is handed off and the next one accepted
//  after reset or a config write the first item first recomputes bias and
//  filter coefficient, with a serial divider that a zero rate skips
//  a finished pair waits in the output register; the next pair is taken
//  meanwhile and only its final transfer stalls on out_ready_i
//  reset is asynchronous active low and clears filter states, control and config registers
// ----------------------------------------------------------------------------
module stereo_tube_overdrive #(
  parameter int SAMPLE_BITS     = sto_pkg::SAMPLE_BITS_DEF,
  parameter int TANH_TABLE_SIZE = sto_pkg::TANH_SIZE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sto_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sto_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]        right_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        left_out_o,
  output logic signed [SAMPLE_BITS-1:0]        right_out_o
);

  localparam int PW     = sto_pkg::MUL_P_W;
  localparam int AW     = sto_pkg::MUL_A_W;
  localparam int BW     = sto_pkg::MUL_B_W;
  localparam int DRY_SH = 25 - SAMPLE_BITS;
  localparam int TA_W   = $clog2(TANH_TABLE_SIZE + 1);
  localparam logic [TA_W-1:0] TA_LAST = TA_W'(TANH_TABLE_SIZE);
  localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

  // config registers
  logic [sto_pkg::KNOB_W-1:0] drive_q, tone_q, level_q, warmth_q, wet_mix_q;
  logic [sto_pkg::RATE_W-1:0] rate_q;
  logic                       dirty_q;

  // sequencer
  sto_pkg::sto_state_e state_q, state_d;
  logic                issued_q;
  logic                ch_q;

  // datapath
  logic signed [SAMPLE_BITS-1:0] smp_q [2];
  logic signed [SAMPLE_BITS-1:0] res_q [2];
  logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;
  logic                          out_valid_q;
  logic [23:0]                   bias_q;
  logic [sto_pkg::DIV_N_W-1:0]   div_num_q;
  logic [sto_pkg::RATIO_W-1:0]   ratio_q;
  logic [sto_pkg::COEF_W-1:0]    coeff_q;
  logic signed [30:0]            x_q;
  logic [30:0]                   m_q;
  logic                          pos_q;
  logic [TA_W-1:0]               addr_q;
  logic [23:0]                   fr_q;
  logic [sto_pkg::TANH_W-1:0]    t0_q, t1_q;
  logic signed [26:0]            tm_q;
  logic signed [25:0]            y_q;
  logic signed [31:0]            frnd_q;
  logic signed [23:0]            st_q [2];
  logic signed [29:0]            wet_q;
  logic signed [PW-1:0]          pd_q, mix_q;

  // shared units
  sto_pkg::mul_req_t            mul_req;
  sto_pkg::div_req_t            div_req;
  logic                         mul_done, div_done;
  logic signed [PW-1:0]         prod;
  logic [sto_pkg::DIV_N_W-1:0]  quot;
  logic [TA_W-1:0]              rom_addr;
  logic [sto_pkg::TANH_W-1:0]   rom_data;

  // derived values
  logic [sto_pkg::KN_W-1:0] kn_drive, kn_tone, kn_level, kn_warmth, kn_mix;
  logic [20:0]              gain;
  logic signed [24:0]       dry;
  logic signed [27:0]       st16;
  logic signed [28:0]       err;
  logic signed [24:0]       tdiff;
  logic [TA_W-1:0]          addr1;
  logic                     x_pos;
  logic                     rate_zero;
  logic                     in_xfer, done_xfer;

  // per-item derived math
  logic [32:0]          idx;
  logic signed [27:0]   yd;
  logic signed [32:0]   s2;
  logic signed [28:0]   s3;
  logic signed [PW-1:0] o_r;
  logic signed [31:0]   m_neg;

  assign kn_drive  = sto_pkg::knob(drive_q);
  assign kn_tone   = sto_pkg::knob(tone_q);
  assign kn_level  = sto_pkg::knob(level_q);
  assign kn_warmth = sto_pkg::knob(warmth_q);
  assign kn_mix    = sto_pkg::knob(wet_mix_q);

  // pre-gain 1 + 19*drive in q.16
  assign gain = 21'(65536) + {kn_drive, 4'b0} + 21'({kn_drive, 1'b0}) + 21'(kn_drive);

  assign dry   = $signed({smp_q[ch_q], {DRY_SH{1'b0}}});
  assign st16  = $signed({st_q[ch_q], 4'b0});
  assign err   = y_q - st16;
  assign tdiff = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
  assign addr1 = (addr_q == TA_LAST) ? addr_q : addr_q + TA_W'(1);
  assign x_pos = x_q > 0;
  assign rate_zero = rate_q == '0;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign done_xfer = (state_q == sto_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  assign idx   = prod[PW-1:27];
  assign yd    = 28'(tm_q) - $signed({5'b0, bias_q[23:1]});
  assign s2    = 33'(st16) + 33'(frnd_q);
  assign s3    = 29'((s2 + 33'sd8) >>> 4);
  assign o_r   = sto_pkg::round_sh(mix_q, DRY_SH);
  assign m_neg = -(32'(x_q) <<< 1);

  sto_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  sto_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  sto_tanh_rom #(
    .TANH_TABLE_SIZE (TANH_TABLE_SIZE)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sto_pkg::S_IDLE:   if (in_xfer) state_d = dirty_q ? sto_pkg::S_BIAS : sto_pkg::S_DRY;
      sto_pkg::S_BIAS:   if (mul_done) state_d = sto_pkg::S_FREQ;
      sto_pkg::S_FREQ:   if (mul_done) state_d = sto_pkg::S_DIV;
      sto_pkg::S_DIV:    if (rate_zero || div_done) state_d = sto_pkg::S_COEF;
      sto_pkg::S_COEF:   if (mul_done) state_d = sto_pkg::S_DRY;
      sto_pkg::S_DRY:    if (mul_done) state_d = sto_pkg::S_POS;
      sto_pkg::S_POS:    if (!x_pos || mul_done) state_d = sto_pkg::S_IDX;
      sto_pkg::S_IDX:    if (mul_done) state_d = sto_pkg::S_T0;
      sto_pkg::S_T0:     state_d = sto_pkg::S_T1;
      sto_pkg::S_T1:     state_d = sto_pkg::S_T2;
      sto_pkg::S_T2:     state_d = sto_pkg::S_INTERP;
      sto_pkg::S_INTERP: if (mul_done) state_d = pos_q ? sto_pkg::S_Y : sto_pkg::S_NEG;
      sto_pkg::S_NEG:    if (mul_done) state_d = sto_pkg::S_Y;
      sto_pkg::S_Y:      state_d = sto_pkg::S_FILT;
      sto_pkg::S_FILT:   if (mul_done) state_d = sto_pkg::S_FSAT;
      sto_pkg::S_FSAT:   state_d = sto_pkg::S_WET;
      sto_pkg::S_WET:    if (mul_done) state_d = sto_pkg::S_MIXD;
      sto_pkg::S_MIXD:   if (mul_done) state_d = sto_pkg::S_MIXW;
      sto_pkg::S_MIXW:   if (mul_done) state_d = sto_pkg::S_RND;
      sto_pkg::S_RND:    state_d = sto_pkg::S_SAT;
      sto_pkg::S_SAT:    state_d = ch_q ? sto_pkg::S_DONE : sto_pkg::S_DRY;
      sto_pkg::S_DONE:   if (done_xfer) state_d = sto_pkg::S_IDLE;
      default:           state_d = sto_pkg::S_IDLE;
    endcase
  end

  // unit requests, table address and input ready
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    div_req.start = (state_q == sto_pkg::S_DIV) && !issued_q && !rate_zero;
    div_req.num   = div_num_q;
    div_req.den   = rate_q;
    rom_addr      = (state_q == sto_pkg::S_T1) ? addr1 : addr_q;
    in_ready_o    = state_q == sto_pkg::S_IDLE;
    case (state_q)
      sto_pkg::S_BIAS: begin
        mul_req.a = $signed(AW'(kn_warmth));
        mul_req.b = sto_pkg::BIAS_K;
      end
      sto_pkg::S_FREQ: begin
        mul_req.a = $signed(AW'(kn_tone));
        mul_req.b = sto_pkg::FREQ_SPAN;
      end
      sto_pkg::S_COEF: begin
        mul_req.a = $signed(sto_pkg::TWO_PI_K);
        mul_req.b = BW'(ratio_q);
      end
      sto_pkg::S_DRY: begin
        mul_req.a = AW'(dry);
        mul_req.b = BW'(gain);
      end
      sto_pkg::S_POS: begin
        mul_req.a = AW'(x_q);
        mul_req.b = sto_pkg::GAIN_POS_K;
      end
      sto_pkg::S_IDX: begin
        mul_req.a = $signed(AW'(m_q));
        mul_req.b = BW'(TANH_TABLE_SIZE);
      end
      sto_pkg::S_INTERP: begin
        mul_req.a = AW'(tdiff);
        mul_req.b = BW'(fr_q);
      end
      sto_pkg::S_NEG: begin
        mul_req.a = AW'(tm_q);
        mul_req.b = sto_pkg::GAIN_NEG_K;
      end
      sto_pkg::S_FILT: begin
        mul_req.a = AW'(err);
        mul_req.b = BW'(coeff_q);
      end
      sto_pkg::S_WET: begin
        mul_req.a = AW'(st16);
        mul_req.b = BW'(kn_level);
      end
      sto_pkg::S_MIXD: begin
        mul_req.a = AW'(dry);
        mul_req.b = BW'(18'(65536) - 18'(kn_mix));
      end
      sto_pkg::S_MIXW: begin
        mul_req.a = AW'(wet_q);
        mul_req.b = BW'(kn_mix);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
    if (!issued_q && (state_q inside {sto_pkg::S_BIAS, sto_pkg::S_FREQ, sto_pkg::S_COEF,
        sto_pkg::S_DRY, sto_pkg::S_IDX, sto_pkg::S_INTERP, sto_pkg::S_NEG,
        sto_pkg::S_FILT, sto_pkg::S_WET, sto_pkg::S_MIXD, sto_pkg::S_MIXW})) begin
      mul_req.start = 1'b1;
    end
    // the positive branch only needs the 1.4 gain product
    if (!issued_q && (state_q == sto_pkg::S_POS) && x_pos) begin
      mul_req.start = 1'b1;
    end
  end

  // control state, config registers and filter states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sto_pkg::S_IDLE;
      issued_q    <= 1'b0;
      ch_q        <= 1'b0;
      dirty_q     <= 1'b1;
      out_valid_q <= 1'b0;
      drive_q     <= '0;
      tone_q      <= '0;
      level_q     <= '0;
      warmth_q    <= '0;
      wet_mix_q   <= 16'hFFFF;
      rate_q      <= 18'd48000;
      st_q[0]     <= '0;
      st_q[1]     <= '0;
    end else begin
      state_q <= state_d;

      if (mul_req.start || div_req.start) begin
        issued_q <= 1'b1;
      end else if (mul_done || div_done) begin
        issued_q <= 1'b0;
      end

      if (in_xfer) begin
        ch_q <= 1'b0;
      end else if (state_q == sto_pkg::S_SAT) begin
        ch_q <= 1'b1;
      end

      if (cfg_valid_i && cfg_ready_o) begin
        dirty_q <= 1'b1;
      end else if ((state_q == sto_pkg::S_COEF) && mul_done) begin
        dirty_q <= 1'b0;
      end

      if (done_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (sto_pkg::cfg_idx_e'(cfg_index_i))
          sto_pkg::CFG_DRIVE:   drive_q   <= cfg_data_i[15:0];
          sto_pkg::CFG_TONE:    tone_q    <= cfg_data_i[15:0];
          sto_pkg::CFG_LEVEL:   level_q   <= cfg_data_i[15:0];
          sto_pkg::CFG_WARMTH:  warmth_q  <= cfg_data_i[15:0];
          sto_pkg::CFG_WET_MIX: wet_mix_q <= cfg_data_i[15:0];
          sto_pkg::CFG_RATE:    rate_q    <= cfg_data_i;
          default: ;
        endcase
      end

      // filter state saturates to its 24 bit range
      if (state_q == sto_pkg::S_FSAT) begin
        if (s3 > 29'sd8388607) begin
          st_q[ch_q] <= 24'sd8388607;
        end else if (s3 < -29'sd8388608) begin
          st_q[ch_q] <= -24'sd8388608;
        end else begin
          st_q[ch_q] <= 24'(s3);
        end
      end
    end
  end

  // datapath captures
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      smp_q[0] <= left_in_i;
      smp_q[1] <= right_in_i;
    end
    if (done_xfer) begin
      out_l_q <= res_q[0];
      out_r_q <= res_q[1];
    end
    case (state_q)
      sto_pkg::S_BIAS: if (mul_done) bias_q <= 24'(sto_pkg::round_sh(prod, 16));
      sto_pkg::S_FREQ: if (mul_done) div_num_q <= {29'(prod) + sto_pkg::FREQ_BASE, 8'b0};
      sto_pkg::S_DIV: begin
        // zero rate takes the clamp value
        if (rate_zero) begin
          ratio_q <= sto_pkg::RATIO_MAX;
        end else if (div_done) begin
          ratio_q <= (quot > sto_pkg::DIV_N_W'(sto_pkg::RATIO_MAX)) ? sto_pkg::RATIO_MAX
                                                                 : quot[23:0];
        end
      end
      sto_pkg::S_COEF: if (mul_done) coeff_q <= 26'(sto_pkg::round_sh(prod, 24));
      sto_pkg::S_DRY: begin
        if (mul_done) begin
          x_q <= 31'(sto_pkg::round_sh(prod, 16) + $signed({1'b0, bias_q}));
        end
      end
      sto_pkg::S_POS: begin
        if (!x_pos) begin
          m_q   <= m_neg[30:0];
          pos_q <= 1'b0;
        end else if (mul_done) begin
          m_q   <= 31'(sto_pkg::round_sh(prod, 16));
          pos_q <= 1'b1;
        end
      end
      sto_pkg::S_IDX: begin
        // arguments of 8 and more take the last entry
        if (mul_done) begin
          if (idx >= 33'(TANH_TABLE_SIZE)) begin
            addr_q <= TA_LAST;
            fr_q   <= '0;
          end else begin
            addr_q <= idx[TA_W-1:0];
            fr_q   <= prod[26:3];
          end
        end
      end
      sto_pkg::S_T1: t0_q <= rom_data;
      sto_pkg::S_T2: t1_q <= rom_data;
      sto_pkg::S_INTERP: begin
        if (mul_done) begin
          tm_q <= 27'($signed({1'b0, t0_q}) + sto_pkg::round_sh(prod, 24));
        end
      end
      sto_pkg::S_NEG: if (mul_done) tm_q <= 27'(-sto_pkg::round_sh(prod, 16));
      sto_pkg::S_Y: begin
        if (yd > 28'sd16777216) begin
          y_q <= 26'sd16777216;
        end else if (yd < -28'sd16777216) begin
          y_q <= -26'sd16777216;
        end else begin
          y_q <= 26'(yd);
        end
      end
      sto_pkg::S_FILT: if (mul_done) frnd_q <= 32'(sto_pkg::round_sh(prod, 24));
      sto_pkg::S_WET:  if (mul_done) wet_q <= 30'(sto_pkg::round_sh(prod, 16));
      sto_pkg::S_MIXD: if (mul_done) pd_q <= prod;
      sto_pkg::S_MIXW: if (mul_done) mix_q <= pd_q + prod;
      sto_pkg::S_RND:  mix_q <= sto_pkg::round_sh(mix_q, 16);
      sto_pkg::S_SAT: begin
        if (o_r > SMAX) begin
          res_q[ch_q] <= SAMPLE_BITS'(SMAX);
        end else if (o_r < SMIN) begin
          res_q[ch_q] <= SAMPLE_BITS'(SMIN);
        end else begin
          res_q[ch_q] <= SAMPLE_BITS'(o_r);
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

endmodule

### sv/sto_mul.sv
// ----------------------------------------------------------------------------
// sto_mul
// digit-serial signed by unsigned multiplier, lsb digit first
// ----------------------------------------------------------------------------
module sto_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sto_pkg::mul_req_t                   req_i,
  output logic                                done_o,
  output logic signed [sto_pkg::MUL_P_W-1:0]  prod_o
);

  localparam int AW    = sto_pkg::MUL_A_W;
  localparam int BW    = sto_pkg::MUL_B_W;
  localparam int DW    = sto_pkg::MUL_DIG_W;
  localparam int NDIG  = BW / DW;
  localparam int CNT_W = $clog2(NDIG + 1);

  logic signed [AW-1:0]   a_q;
  logic        [BW-1:0]   b_q;
  logic signed [AW+DW:0]  acc_q, acc_d, part, sum;
  logic        [BW-1:0]   lo_q, lo_d;
  logic        [CNT_W-1:0] cnt_q;
  logic                   done_q;

  always_comb begin
    part  = a_q * $signed({1'b0, b_q[DW-1:0]});
    sum   = acc_q + part;
    acc_d = sum >>> DW;
    lo_d  = {sum[DW-1:0], lo_q[BW-1:DW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1)) && !req_i.start;
      if (req_i.start) begin
        cnt_q <= CNT_W'(NDIG);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
      lo_q  <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= acc_d;
      lo_q  <= lo_d;
      b_q   <= b_q >> DW;
    end
  end

  assign done_o = done_q;
  assign prod_o = $signed({acc_q[AW-1:0], lo_q});

endmodule

### sv/sto_div.sv
// ----------------------------------------------------------------------------
// sto_div
// bit-serial restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module sto_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sto_pkg::div_req_t             req_i,
  output logic                          done_o,
  output logic [sto_pkg::DIV_N_W-1:0]   quot_o
);

  localparam int NW    = sto_pkg::DIV_N_W;
  localparam int DWD   = sto_pkg::DIV_D_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    qr_q;
  logic [DWD-1:0]   rem_q, den_q, rem_d;
  logic [DWD:0]     trial, diff;
  logic             ge;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  always_comb begin
    trial = {rem_q, qr_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DWD-1:0] : trial[DWD-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1)) && !req_i.start;
      if (req_i.start) begin
        cnt_q <= CNT_W'(NW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      qr_q  <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      qr_q  <= {qr_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = qr_q;

endmodule

### sv/sto_tanh_rom.sv
// ----------------------------------------------------------------------------
// sto_tanh_rom
// tanh table over arguments 0..8, built at elaboration, registered read
// ----------------------------------------------------------------------------
module sto_tanh_rom #(
  parameter int TANH_TABLE_SIZE = sto_pkg::TANH_SIZE_DEF
) (
  input  logic                               clk_i,
  input  logic [$clog2(TANH_TABLE_SIZE+1)-1:0] addr_i,
  output logic [sto_pkg::TANH_W-1:0]         data_o
);

  typedef logic [sto_pkg::TANH_W-1:0] tab_t [TANH_TABLE_SIZE+1];

  // shift and subtract long division, only evaluated at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16/N) by taylor series, then powers of it give each entry
  function automatic tab_t build_tab();
    logic signed [63:0] term;
    logic signed [63:0] sum;
    logic        [63:0] e;
    logic        [63:0] den;
    logic        [63:0] num;
    tab_t               t;
    term = 64'sd1 <<< 32;
    sum  = term;
    e    = 64'd1 << 32;
    for (int n = 1; n <= 14; n++) begin
      term = $signed(udiv64(64'(term * 64'sd16), 64'(TANH_TABLE_SIZE * n)));
      sum  = ((n & 1) != 0) ? sum - term : sum + term;
    end
    for (int k = 0; k <= TANH_TABLE_SIZE; k++) begin
      den  = (64'd1 << 32) + e;
      num  = ((64'd1 << 32) - e) << 24;
      t[k] = sto_pkg::TANH_W'(udiv64(num + (den >> 1), den));
      e    = (e * 64'(sum) + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [sto_pkg::TANH_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= TAB[addr_i];
  end

  assign data_o = data_q;

endmodule

### tb/stereo_tube_overdrive_test.sv
// ----------------------------------------------------------------------------
// stereo_tube_overdrive_test
// self-checking bench for the stereo tube overdrive: a directed table of
// register writes and sample pairs, then randomized sample pairs under three
// idling patterns, every output pair compared with a hand-typed expectation
// or a bit-exact software model of the fixed-point datapath kept inside the bench
// ----------------------------------------------------------------------------
module stereo_tube_overdrive_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB         = 16;
  localparam int TAB_N      = 256;
  localparam int DRAIN_WAIT = 300;    // idle wait after the last pending pair is out
  localparam int STALL_MAX  = 20000;  // cycles without any transfer
  localparam logic [sto_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [sto_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } pair_t;

  // one directed row: a register write or a sample pair with optional
  // hand-typed expectation
  typedef struct packed {
    logic                           is_cfg;
    logic [sto_pkg::CFG_IDX_W-1:0]  idx;
    logic [sto_pkg::CFG_DATA_W-1:0] data;
    pair_t                          smp;
    logic                           typed;
    pair_t                          want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sto_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [sto_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SB-1:0] left_in_i = '0;
  logic signed [SB-1:0] right_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SB-1:0] left_out_o;
  logic signed [SB-1:0] right_out_o;

  stereo_tube_overdrive u_top (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  longint tanh_lut[TAB_N+1];
  logic [15:0] m_drive, m_tone, m_level, m_warmth, m_mix;
  logic [17:0] m_rate;
  longint lp_left, lp_right;  // tone filter states, Q3.20

  pair_t pending_q[$];
  int    n_fail = 0;
  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  int    quiet_cycles = 0;

  function automatic longint kn(logic [15:0] k);
    return longint'(k) + longint'(k[15]);
  endfunction

  // round half up, arithmetic shift floors
  function automatic longint rsh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // table of tanh over 0..8, built with the same rounded exp recursion
  function automatic void build_tanh_lut();
    longint term, sum;
    longint unsigned e, den, num;
    term = longint'(1) << 32;
    sum  = term;
    for (int n = 1; n <= 14; n++) begin
      term = term * 16 / (longint'(TAB_N) * n);
      sum  = (n % 2 == 1) ? sum - term : sum + term;
    end
    e = 64'd1 << 32;
    for (int k = 0; k <= TAB_N; k++) begin
      den = (64'd1 << 32) + e;
      num = ((64'd1 << 32) - e) << 24;
      tanh_lut[k] = longint'((num + den / 2) / den);
      e = (e * longint'(unsigned'(sum)) + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic longint tanh_pos(longint m);
    longint p, ix, fr, t0, t1;
    p  = (m * TAB_N) >>> 3;
    ix = p >>> 24;
    if (ix >= TAB_N) return tanh_lut[TAB_N];
    fr = p & 64'hFF_FFFF;
    t0 = tanh_lut[ix];
    t1 = tanh_lut[ix+1];
    return t0 + rsh((t1 - t0) * fr, 24);
  endfunction

  // pre-gain, bias, asymmetric tanh, bias removal, clamp to [-1,1]
  function automatic longint tube_shape(longint x24);
    longint gain, bias, x, y;
    gain = 65536 + 19 * kn(m_drive);
    bias = rsh(kn(m_warmth) * longint'(sto_pkg::BIAS_K), 16);
    x = rsh(x24 * gain, 16) + bias;
    if (x > 0) y = tanh_pos(rsh(x * longint'(sto_pkg::GAIN_POS_K), 16));
    else y = -rsh(tanh_pos(-2 * x) * longint'(sto_pkg::GAIN_NEG_K), 16);
    y -= bias >>> 1;
    if (y > (longint'(1) << 24)) y = longint'(1) << 24;
    if (y < -(longint'(1) << 24)) y = -(longint'(1) << 24);
    return y;
  endfunction

  function automatic longint tone_coeff();
    longint freq, ratio;
    freq  = 500 * 65536 + 7000 * kn(m_tone);
    ratio = longint'(sto_pkg::RATIO_MAX);
    // zero sample rate falls back to the clamp value
    if (m_rate != 0) begin
      ratio = (freq * 256) / longint'(m_rate);
      if (ratio > longint'(sto_pkg::RATIO_MAX)) ratio = longint'(sto_pkg::RATIO_MAX);
    end
    return rsh(ratio * longint'(sto_pkg::TWO_PI_K), 24);
  endfunction

  function automatic logic signed [SB-1:0] overdrive_channel(
    logic signed [SB-1:0] raw, inout longint st, input longint c
  );
    longint dry, s, wet, o;
    dry = longint'(raw) * 512;
    s = st * 16;
    s += rsh(c * (tube_shape(dry) - s), 24);
    s = rsh(s, 4);
    // unstable filter at low rates: state saturates
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    st = s;
    wet = rsh(s * 16 * kn(m_level), 16);
    o = rsh(dry * (65536 - kn(m_mix)) + wet * kn(m_mix), 16);
    o = rsh(o, 25 - SB);
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return SB'(o);
  endfunction

  function automatic pair_t overdrive_pair(pair_t p);
    longint c;
    pair_t r;
    c = tone_coeff();
    r.left  = overdrive_channel(p.left, lp_left, c);
    r.right = overdrive_channel(p.right, lp_right, c);
    return r;
  endfunction

  function automatic void apply_reg(logic [sto_pkg::CFG_IDX_W-1:0] idx,
                                    logic [sto_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      sto_pkg::CFG_DRIVE:   m_drive = d[15:0];
      sto_pkg::CFG_TONE:    m_tone = d[15:0];
      sto_pkg::CFG_LEVEL:   m_level = d[15:0];
      sto_pkg::CFG_WARMTH:  m_warmth = d[15:0];
      sto_pkg::CFG_WET_MIX: m_mix = d[15:0];
      sto_pkg::CFG_RATE:    m_rate = d;
      default: ;  // spare indexes are ignored
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers
  // receiver stalls at random
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_idle_pct);

  // check every output transfer against the oldest expectation
  always @(posedge clk_i) begin
    pair_t w;
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected output pair left=%0d right=%0d", left_out_o, right_out_o);
        n_fail++;
      end else begin
        w = pending_q.pop_front();
        if (left_out_o !== w.left) begin
          $error("left_out expected %0d actual %0d", w.left, left_out_o);
          n_fail++;
        end
        if (right_out_o !== w.right) begin
          $error("right_out expected %0d actual %0d", w.right, right_out_o);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // send one sample pair; valid stays high afterwards for back-to-back transfer
  task automatic send_pair(pair_t p, logic typed, pair_t want);
    pair_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i  <= p.left;
    right_in_i <= p.right;
    do @(posedge clk_i); while (!in_ready_o);
    got = overdrive_pair(p);
    pending_q.push_back(typed ? want : got);
  endtask

  // hold off input until every pending pair is out and the datapath is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sto_pkg::CFG_IDX_W-1:0] idx,
                           logic [sto_pkg::CFG_DATA_W-1:0] d);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, d);
  endtask

  function automatic logic [15:0] rand_knob();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [17:0] rand_rate();
    case ($urandom_range(7))
      0: return 18'd8000;
      1: return 18'd192000;
      2: return 18'($urandom_range(262143));  // odd values, all bits
      default: return 18'($urandom_range(192000, 8000));
    endcase
  endfunction

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'($signed(12'($urandom_range(4095))));  // quiet signal
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  row_t plan[] = '{
    // after reset level is zero and mix fully wet: silence
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{16'sh7FFF, -16'sh8000}, 1'b1, '{16'sd0, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{16'sd1, -16'sd1}, 1'b1, '{16'sd0, 16'sd0}},
    // fully dry: output equals input
    '{1'b1, sto_pkg::CFG_WET_MIX, 18'd0, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{16'sh7FFF, -16'sh8000}, 1'b1,
      '{16'sh7FFF, -16'sh8000}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{-16'sd1, 16'sd0}, 1'b1, '{-16'sd1, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{16'sh5555, -16'sh5556}, 1'b1,
      '{16'sh5555, -16'sh5556}},
    // every knob at full scale, lowest rate: unstable filter
    '{1'b1, sto_pkg::CFG_DRIVE, 18'h0FFFF, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b1, sto_pkg::CFG_TONE, 18'h3FFFF, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b1, sto_pkg::CFG_LEVEL, 18'h0FFFF, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b1, sto_pkg::CFG_WARMTH, 18'h0FFFF, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b1, sto_pkg::CFG_WET_MIX, 18'h0FFFF, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b1, sto_pkg::CFG_RATE, 18'd8000, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{16'sh7FFF, 16'sh7FFF}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{-16'sh8000, -16'sh8000}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{16'sd12345, -16'sd23456}, 1'b0, '{16'sd0, 16'sd0}},
    // zero sample rate uses the clamped ratio
    '{1'b1, sto_pkg::CFG_RATE, 18'd0, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{16'sh7FFF, -16'sh8000}, 1'b0, '{16'sd0, 16'sd0}},
    // spare register indexes change nothing
    '{1'b1, IDX_SPARE_LO, 18'h3FFFF, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b1, IDX_SPARE_HI, 18'h3FFFF, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{16'sd100, -16'sd100}, 1'b0, '{16'sd0, 16'sd0}},
    // highest rate, no drive or warmth
    '{1'b1, sto_pkg::CFG_RATE, 18'd192000, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b1, sto_pkg::CFG_DRIVE, 18'd0, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b1, sto_pkg::CFG_WARMTH, 18'd0, '{16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{1'b0, sto_pkg::CFG_DRIVE, 18'd0, '{-16'sd20000, 16'sd20000}, 1'b0, '{16'sd0, 16'sd0}}
  };

  initial begin
    pair_t p;
    build_tanh_lut();
    m_drive = '0; m_tone = '0; m_level = '0; m_warmth = '0;
    m_mix = 16'hFFFF; m_rate = 18'd48000;
    lp_left = 0; lp_right = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send_pair(plan[i].smp, plan[i].typed, plan[i].want);
    end

    // three idling patterns, each with fresh register settings
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 73 : 0;
      rx_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 28 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        write_reg(sto_pkg::CFG_DRIVE, {2'($urandom_range(3)), rand_knob()});
        write_reg(sto_pkg::CFG_TONE, {2'($urandom_range(3)), rand_knob()});
        write_reg(sto_pkg::CFG_LEVEL, {2'($urandom_range(3)), rand_knob()});
        write_reg(sto_pkg::CFG_WARMTH, {2'($urandom_range(3)), rand_knob()});
        write_reg(sto_pkg::CFG_WET_MIX, {2'($urandom_range(3)), rand_knob()});
        write_reg(sto_pkg::CFG_RATE, rand_rate());
        for (int n = 0; n < 105; n++) begin
          p.left  = rand_sample();
          p.right = rand_sample();
          send_pair(p, 1'b0, p);
          // sender holds off once a block until everything is out
          if (n == 50) drain();
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_fail == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
